// File: sv/wmie_pkg.sv
// Shared types and constants for the word machine instruction executor.
// Used by every module of the block except wmie_ram; depends on nothing else.
package wmie_pkg;

  // Default machine geometry
  localparam int WMIE_MEM_WORDS   = 100;
  localparam int WMIE_BLOCK_WORDS = 10;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Character codes used by the instruction decoder
  localparam logic [7:0] CH_0 = 8'd48;
  localparam logic [7:0] CH_9 = 8'd57;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_T = 8'h54;

  // Request type codes on the input channel
  localparam logic [2:0] REQ_NEWJOB = 3'd0;
  localparam logic [2:0] REQ_PROG   = 3'd1;
  localparam logic [2:0] REQ_START  = 3'd2;
  localparam logic [2:0] REQ_STEP   = 3'd3;
  localparam logic [2:0] REQ_DATA   = 3'd4;

  // Result status codes
  typedef enum logic [2:0] {
    STS_DONE = 3'd0,
    STS_NEED = 3'd1,
    STS_OUT  = 3'd2,
    STS_HALT = 3'd3,
    STS_ERR  = 3'd4
  } status_t;

  // Command class produced by the front
  typedef enum logic [2:0] {
    CMD_NEWJOB = 3'd0,
    CMD_PROG   = 3'd1,
    CMD_START  = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_DATA   = 3'd4,
    CMD_BAD    = 3'd5
  } cmd_t;

  // Machine run mode
  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_RUN  = 4'b0010,
    MODE_WAIT = 4'b0100,
    MODE_STOP = 4'b1000
  } mode_t;

  // Back end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE    = 4'b0001,
    BK_DECODE  = 4'b0010,
    BK_OPERAND = 4'b0100,
    BK_BURST   = 4'b1000
  } bk_state_t;

  // Input transaction payload
  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] word;
  } req_t;

  // Output transaction payload
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_word;
    logic        last;
    logic [6:0]  counter_now;
  } rsp_t;

  // Queue entry between front and back
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] word;
  } q_item_t;

endpackage

// File: sv/word_machine_instruction_executor.sv
// Top level of the word machine instruction executor: front, queue, back.
// Depends on wmie_pkg, wmie_front, wmie_queue, wmie_back.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_t  (req_type, word)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_t  (status, out_word, last, counter_now)
//
// New job, program word, start, data word and non-running steps are handled in idle.
// A running step passes through fetch and decode, plus an operand read for LR and CR;
// PD then bursts BLOCK_WORDS words from the single RAM read port, one a cycle unless stalled.
// The front accepts into a 2-entry queue while the back works or is stalled.
// Reset is synchronous and clears the word store through per-word valid bits at
// once; no clearing pass is needed. Output stall holds the result register.
module word_machine_instruction_executor import wmie_pkg::*; #(
  parameter int MEM_WORDS   = WMIE_MEM_WORDS,
  parameter int BLOCK_WORDS = WMIE_BLOCK_WORDS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic    push, q_full, q_valid, q_pop;
  q_item_t push_item, q_item;

  wmie_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .item      (push_item),
    .q_full    (q_full)
  );

  wmie_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (q_pop)
  );

  wmie_back #(
    .MEM_WORDS   (MEM_WORDS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// File: sv/wmie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module wmie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/wmie_front.sv
// Front end: accepts request transactions and classifies them into commands.
// Depends on wmie_pkg; feeds wmie_queue.
module wmie_front import wmie_pkg::*; (
  input  logic    req_valid,
  output logic    req_stall,
  input  req_t    req,
  output logic    push,
  output q_item_t item,
  input  logic    q_full
);

  // Stall only on a full queue
  assign req_stall = q_full;
  assign push      = req_valid && !q_full;

  // Classify the request type
  always_comb begin
    item.word = req.word;
    case (req.req_type)
      REQ_NEWJOB: item.cmd = CMD_NEWJOB;
      REQ_PROG:   item.cmd = CMD_PROG;
      REQ_START:  item.cmd = CMD_START;
      REQ_STEP:   item.cmd = CMD_STEP;
      REQ_DATA:   item.cmd = CMD_DATA;
      default:    item.cmd = CMD_BAD;
    endcase
  end

endmodule

// File: sv/wmie_queue.sv
// Short command queue between front and back end.
// Depends on wmie_pkg for the entry type and depth.
module wmie_queue import wmie_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  output logic    q_valid,
  output q_item_t q_item,
  input  logic    pop
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  q_item_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FullCnt);
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: sv/wmie_back.sv
// Back end: carries out commands against the word store and machine registers.
// Depends on wmie_pkg and wmie_ram; drives the result channel.
module wmie_back import wmie_pkg::*; #(
  parameter int MEM_WORDS   = WMIE_MEM_WORDS,
  parameter int BLOCK_WORDS = WMIE_BLOCK_WORDS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  q_item_t q_item,
  output logic    q_pop,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output rsp_t    rsp
);

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [6:0] MemLim   = 7'(MEM_WORDS);
  localparam logic [6:0] BlkWords = 7'(BLOCK_WORDS);
  localparam logic [3:0] BlkCnt   = 4'(BLOCK_WORDS);
  localparam logic [3:0] BlkLast  = 4'(BLOCK_WORDS - 1);

  // Architectural state
  bk_state_t      state, state_next;
  mode_t          mode, mode_next;
  logic [6:0]     ic, ic_next;
  logic [31:0]    gr, gr_next;
  logic           flag, flag_next;
  logic [6:0]     lp, lp_next;
  logic [3:0]     di, di_next;
  logic [6:0]     dbase, dbase_next;
  logic           oper_cr, oper_cr_next;
  logic [AW-1:0]  pd_addr, pd_addr_next;
  logic [3:0]     pd_cnt, pd_cnt_next;
  logic [MEM_WORDS-1:0] vld;
  logic           rd_vld;
  rsp_t           rsp_next;

  // Memory port signals
  logic           we, re, vld_clr;
  logic [AW-1:0]  waddr, raddr;
  logic [31:0]    wdata, rdata, rdw;
  logic [6:0]     daddr7;

  // Result staging
  logic           emit, out_free;
  status_t        e_status;
  logic [31:0]    e_word;
  logic           e_last;

  // Instruction decode from the fetched word
  logic [7:0]     c0, c1, c2, c3;
  logic [6:0]     d2, d3, addr7, base7;
  logic           digits_ok, addr_ok, block_ok;
  logic           is_gd, is_pd, is_h, is_lr, is_sr, is_cr, is_bt;

  wmie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entries never written since the last new job read as zero
  assign rdw      = rd_vld ? rdata : '0;
  assign out_free = !rsp_valid || !rsp_stall;

  // Store address of the next data word in the pending block
  assign daddr7 = dbase + {3'b000, di};

  assign c0 = rdw[31:24];
  assign c1 = rdw[23:16];
  assign c2 = rdw[15:8];
  assign c3 = rdw[7:0];
  assign d2 = {3'b000, c2[3:0]};
  assign d3 = {3'b000, c3[3:0]};
  assign digits_ok = (c2 >= CH_0) && (c2 <= CH_9) && (c3 >= CH_0) && (c3 <= CH_9);
  assign base7     = d2 * 7'd10;
  assign addr7     = base7 + d3;
  assign addr_ok   = digits_ok && (addr7 < MemLim);
  assign block_ok  = digits_ok && ((base7 + BlkWords) <= MemLim);

  assign is_gd = (c0 == CH_G) && (c1 == CH_D);
  assign is_pd = (c0 == CH_P) && (c1 == CH_D);
  assign is_h  = (c0 == CH_H);
  assign is_lr = (c0 == CH_L) && (c1 == CH_R);
  assign is_sr = (c0 == CH_S) && (c1 == CH_R);
  assign is_cr = (c0 == CH_C) && (c1 == CH_R);
  assign is_bt = (c0 == CH_B) && (c1 == CH_T);

  // Sequencer and datapath next values
  always_comb begin
    state_next   = state;
    mode_next    = mode;
    ic_next      = ic;
    gr_next      = gr;
    flag_next    = flag;
    lp_next      = lp;
    di_next      = di;
    dbase_next   = dbase;
    oper_cr_next = oper_cr;
    pd_addr_next = pd_addr;
    pd_cnt_next  = pd_cnt;
    q_pop        = 1'b0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = q_item.word;
    re           = 1'b0;
    raddr        = '0;
    vld_clr      = 1'b0;
    emit         = 1'b0;
    e_status     = STS_DONE;
    e_word       = '0;
    e_last       = 1'b1;

    case (state)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          case (q_item.cmd)
            CMD_NEWJOB: begin
              vld_clr    = 1'b1;
              ic_next    = '0;
              gr_next    = '0;
              flag_next  = 1'b0;
              lp_next    = '0;
              di_next    = '0;
              dbase_next = '0;
              mode_next  = MODE_IDLE;
            end
            CMD_PROG: begin
              if (lp >= MemLim) begin
                e_status = STS_ERR;
              end else begin
                we      = 1'b1;
                waddr   = lp[AW-1:0];
                lp_next = lp + 7'd1;
              end
            end
            CMD_START: begin
              ic_next   = '0;
              mode_next = MODE_RUN;
            end
            CMD_STEP: begin
              case (mode)
                MODE_RUN: begin
                  if (ic >= MemLim) begin
                    mode_next = MODE_STOP;
                    e_status  = STS_ERR;
                  end else begin
                    // Fetch the instruction; result comes from decode
                    emit       = 1'b0;
                    re         = 1'b1;
                    raddr      = ic[AW-1:0];
                    state_next = BK_DECODE;
                  end
                end
                MODE_WAIT: e_status = STS_NEED;
                MODE_STOP: e_status = STS_HALT;
                default:   e_status = STS_ERR;
              endcase
            end
            CMD_DATA: begin
              if (mode != MODE_WAIT || di >= BlkCnt || daddr7 >= MemLim) begin
                e_status = STS_ERR;
              end else begin
                we    = 1'b1;
                waddr = daddr7[AW-1:0];
                if ((di + 4'd1) >= BlkCnt) begin
                  di_next   = '0;
                  mode_next = MODE_RUN;
                end else begin
                  di_next  = di + 4'd1;
                  e_status = STS_NEED;
                end
              end
            end
            default: e_status = STS_ERR;
          endcase
        end
      end

      BK_DECODE: begin
        ic_next    = ic + 7'd1;
        state_next = BK_IDLE;
        emit       = 1'b1;
        if (is_gd) begin
          if (!block_ok) begin
            mode_next = MODE_STOP;
            e_status  = STS_ERR;
          end else begin
            dbase_next = base7;
            di_next    = '0;
            mode_next  = MODE_WAIT;
            e_status   = STS_NEED;
          end
        end else if (is_pd) begin
          if (!block_ok) begin
            mode_next = MODE_STOP;
            e_status  = STS_ERR;
          end else begin
            emit         = 1'b0;
            re           = 1'b1;
            raddr        = base7[AW-1:0];
            pd_addr_next = base7[AW-1:0];
            pd_cnt_next  = '0;
            state_next   = BK_BURST;
          end
        end else if (is_h) begin
          mode_next = MODE_STOP;
          e_status  = STS_HALT;
        end else if (is_lr || is_sr || is_cr || is_bt) begin
          if (!addr_ok) begin
            mode_next = MODE_STOP;
            e_status  = STS_ERR;
          end else if (is_lr || is_cr) begin
            // Read the operand; result comes next cycle
            emit         = 1'b0;
            re           = 1'b1;
            raddr        = addr7[AW-1:0];
            oper_cr_next = is_cr;
            state_next   = BK_OPERAND;
          end else if (is_sr) begin
            we    = 1'b1;
            waddr = addr7[AW-1:0];
            wdata = gr;
          end else if (flag) begin
            ic_next = addr7;
          end
        end
      end

      BK_OPERAND: begin
        emit       = 1'b1;
        state_next = BK_IDLE;
        if (oper_cr) begin
          flag_next = (rdw == gr);
        end else begin
          gr_next = rdw;
        end
      end

      BK_BURST: begin
        // Emit one block word per free output slot, prefetching the next
        if (out_free) begin
          emit     = 1'b1;
          e_status = STS_OUT;
          e_word   = rdw;
          e_last   = (pd_cnt == BlkLast);
          if (pd_cnt == BlkLast) begin
            state_next = BK_IDLE;
          end else begin
            pd_cnt_next  = pd_cnt + 4'd1;
            pd_addr_next = pd_addr + AW'(1);
            re           = 1'b1;
            raddr        = pd_addr + AW'(1);
          end
        end
      end

      default: state_next = BK_IDLE;
    endcase

    rsp_next.status      = e_status;
    rsp_next.out_word    = e_word;
    rsp_next.last        = e_last;
    rsp_next.counter_now = ic_next;
  end

  // Control and machine registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      mode      <= MODE_IDLE;
      ic        <= '0;
      gr        <= '0;
      flag      <= 1'b0;
      lp        <= '0;
      di        <= '0;
      dbase     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      ic    <= ic_next;
      gr    <= gr_next;
      flag  <= flag_next;
      lp    <= lp_next;
      di    <= di_next;
      dbase <= dbase_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Word valid bits: clear all at once, set on write
  always_ff @(posedge clk) begin
    if (rst || vld_clr) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    oper_cr <= oper_cr_next;
    pd_addr <= pd_addr_next;
    pd_cnt  <= pd_cnt_next;
    if (re) begin
      rd_vld <= vld[raddr];
    end
    if (emit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: sv/wmie_checker.sv
// Port-level checks on the result channel of the executor, with its bind.
// Depends on wmie_pkg; attaches to word_machine_instruction_executor.
module wmie_checker import wmie_pkg::*; #(
  parameter int MEM_WORDS = WMIE_MEM_WORDS
) (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Only block output words may be non-final
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STS_OUT |-> rsp.last)
    else $error("non-output result without last");

  // Only block output words carry data
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STS_OUT |-> rsp.out_word == '0)
    else $error("non-output result with data");

  // Counter never exceeds the store size
  a_counter: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.counter_now <= 7'(MEM_WORDS))
    else $error("counter past store size");

endmodule

bind word_machine_instruction_executor wmie_checker #(.MEM_WORDS(MEM_WORDS)) u_wmie_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
